// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the rtl of the dma block and list transfer block
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define DMABLT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition that must never be seen outside reset
`define DMABLT_NEVER(label, cond, msg) \
   `DMABLT_ASSERT(label, !(cond), msg)

`endif

// ----- rtl/core/dmablt_pkg.sv -----
// types, codes and constants of the dma block and list transfer block
// no dependencies; used by the core, the result queue and the top level
package dmablt_pkg;

   // operation codes of an input transfer
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_READ_DATA = 2'd1;
   localparam logic [1:0] OP_WRITE_ACK = 2'd2;

   // result kinds
   localparam logic [2:0] K_READ = 3'd0;
   localparam logic [2:0] K_WRITE = 3'd1;
   localparam logic [2:0] K_GPU = 3'd2;
   localparam logic [2:0] K_DONE = 3'd3;
   localparam logic [2:0] K_ERROR = 3'd4;

   // channel kinds
   localparam logic [1:0] CH_GPU = 2'd0;
   localparam logic [1:0] CH_OT = 2'd1;

   // ordering table end marker
   localparam logic [31:0] OT_END = 32'h00FF_FFFF;

   // result queue geometry
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   typedef struct packed {
      logic [23:0] base_address;
      logic [23:0] word_count;
      logic        step_down;
      logic        from_ram;
      logic        linked_list;
      logic [1:0]  channel_kind;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [20:0] address;
      logic [31:0] data;
      logic        last;
   } result_type;

   // up to two results caused by one input transfer
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } step_type;

   typedef struct packed {
      logic                  valid;
      logic                  room2;
      logic [FIFO_CNT_W-1:0] count;
   } fifo_status_type;

   function automatic result_type make_result(input logic [2:0] kind,
                                              input logic [20:0] address,
                                              input logic [31:0] data);
      result_type r;
      r.kind = kind;
      r.address = address;
      r.data = data;
      r.last = 1'b0;
      return r;
   endfunction

endpackage

// ----- rtl/core/dmablt_core.sv -----
// transfer sequencer: channel state and the results of one input transfer
// depends on dmablt_pkg
module dmablt_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                go,
   input  logic [1:0]          op,
   input  logic [31:0]         rd,
   input  dmablt_pkg::cfg_type cfg,
   output dmablt_pkg::step_type step
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_BLOCK = 2'd1;
   localparam logic [1:0] PH_HEAD = 2'd2;
   localparam logic [1:0] PH_WORD = 2'd3;

   logic [1:0]  phase_ff, phase_in;
   logic [20:0] cur_ff, cur_in;
   logic [23:0] left_ff, left_in;
   logic [18:0] next_hdr_ff, next_hdr_in;
   logic        end_ff, end_in;
   logic        lat_from_ff, lat_from_in;
   logic        lat_down_ff, lat_down_in;

   logic [20:0] wa, cur_step, wa_step, cur_inc, base_wa, hdr_wa, rd_hdr_wa;
   logic [23:0] left_dec;

   // ordering table word: link to previous address, end marker on the last one
   function automatic dmablt_pkg::result_type ot_result(input logic [20:0] a,
                                                        input logic [23:0] left);
      logic [20:0] prev;
      prev = a - 21'd4;
      return dmablt_pkg::make_result(dmablt_pkg::K_WRITE, a,
                                     (left == 24'd1) ? dmablt_pkg::OT_END
                                                     : {11'd0, prev});
   endfunction

   // address arithmetic
   assign wa = {cur_ff[20:2], 2'b00};
   assign cur_step = lat_down_ff ? (cur_ff - 21'd4) : (cur_ff + 21'd4);
   assign wa_step = {cur_step[20:2], 2'b00};
   assign cur_inc = {cur_ff[20:2] + 19'd1, 2'b00};
   assign base_wa = {cfg.base_address[20:2], 2'b00};
   assign hdr_wa = {next_hdr_ff, 2'b00};
   assign rd_hdr_wa = {rd[20:2], 2'b00};
   assign left_dec = left_ff - 24'd1;

   // next state and results
   always_comb begin
      dmablt_pkg::result_type r0, r1;
      logic [1:0] n;
      logic       bad;
      r0 = '0;
      r1 = '0;
      n = 2'd0;
      bad = 1'b0;
      phase_in = phase_ff;
      cur_in = cur_ff;
      left_in = left_ff;
      next_hdr_in = next_hdr_ff;
      end_in = end_ff;
      lat_from_in = lat_from_ff;
      lat_down_in = lat_down_ff;

      if (op == dmablt_pkg::OP_START) begin
         if (phase_ff == PH_IDLE) begin
            cur_in = cfg.base_address[20:0];
            lat_from_in = cfg.from_ram;
            lat_down_in = cfg.step_down;
            if (cfg.linked_list) begin
               if (!cfg.from_ram || cfg.channel_kind != dmablt_pkg::CH_GPU) begin
                  r0 = dmablt_pkg::make_result(dmablt_pkg::K_ERROR, '0, '0);
                  n = 2'd1;
               end else begin
                  left_in = '0;
                  end_in = 1'b0;
                  phase_in = PH_HEAD;
                  r0 = dmablt_pkg::make_result(dmablt_pkg::K_READ, base_wa, '0);
                  n = 2'd1;
               end
            end else begin
               bad = cfg.from_ram ? (cfg.channel_kind != dmablt_pkg::CH_GPU)
                                  : (cfg.channel_kind != dmablt_pkg::CH_OT);
               n = 2'd1;
               if (bad) begin
                  r0 = dmablt_pkg::make_result(dmablt_pkg::K_ERROR, '0, '0);
               end else begin
                  left_in = cfg.word_count;
                  if (cfg.word_count == 24'd0) begin
                     r0 = dmablt_pkg::make_result(dmablt_pkg::K_DONE, '0, '0);
                  end else begin
                     phase_in = PH_BLOCK;
                     if (cfg.from_ram) begin
                        r0 = dmablt_pkg::make_result(dmablt_pkg::K_READ, base_wa, '0);
                     end else begin
                        r0 = ot_result(base_wa, cfg.word_count);
                     end
                  end
               end
            end
         end
      end else begin
         unique case (phase_ff)
            PH_BLOCK: begin
               if (lat_from_ff ? (op == dmablt_pkg::OP_READ_DATA)
                               : (op == dmablt_pkg::OP_WRITE_ACK)) begin
                  cur_in = cur_step;
                  left_in = left_dec;
                  if (lat_from_ff) begin
                     r0 = dmablt_pkg::make_result(dmablt_pkg::K_GPU, wa, rd);
                     if (left_dec == 24'd0) begin
                        r1 = dmablt_pkg::make_result(dmablt_pkg::K_DONE, '0, '0);
                     end else begin
                        r1 = dmablt_pkg::make_result(dmablt_pkg::K_READ, wa_step, '0);
                     end
                     n = 2'd2;
                  end else begin
                     if (left_dec == 24'd0) begin
                        r0 = dmablt_pkg::make_result(dmablt_pkg::K_DONE, '0, '0);
                     end else begin
                        r0 = ot_result(wa_step, left_dec);
                     end
                     n = 2'd1;
                  end
                  if (left_dec == 24'd0) begin
                     phase_in = PH_IDLE;
                  end
               end
            end
            PH_HEAD: begin
               if (op == dmablt_pkg::OP_READ_DATA) begin
                  left_in = {16'd0, rd[31:24]};
                  end_in = rd[23];
                  next_hdr_in = rd[20:2];
                  n = 2'd1;
                  if (rd[31:24] != 8'd0) begin
                     cur_in = cur_inc;
                     phase_in = PH_WORD;
                     r0 = dmablt_pkg::make_result(dmablt_pkg::K_READ, cur_inc, '0);
                  end else if (rd[23]) begin
                     phase_in = PH_IDLE;
                     r0 = dmablt_pkg::make_result(dmablt_pkg::K_DONE, '0, '0);
                  end else begin
                     cur_in = rd_hdr_wa;
                     r0 = dmablt_pkg::make_result(dmablt_pkg::K_READ, rd_hdr_wa, '0);
                  end
               end
            end
            PH_WORD: begin
               if (op == dmablt_pkg::OP_READ_DATA) begin
                  r0 = dmablt_pkg::make_result(dmablt_pkg::K_GPU, wa, rd);
                  n = 2'd2;
                  left_in = left_dec;
                  if (left_dec != 24'd0) begin
                     cur_in = cur_inc;
                     r1 = dmablt_pkg::make_result(dmablt_pkg::K_READ, cur_inc, '0);
                  end else if (end_ff) begin
                     phase_in = PH_IDLE;
                     r1 = dmablt_pkg::make_result(dmablt_pkg::K_DONE, '0, '0);
                  end else begin
                     cur_in = hdr_wa;
                     phase_in = PH_HEAD;
                     r1 = dmablt_pkg::make_result(dmablt_pkg::K_READ, hdr_wa, '0);
                  end
               end
            end
            default: begin
               // idle: responses are ignored
            end
         endcase
      end

      // last marks the final result of this transfer
      if (n == 2'd1) begin
         r0.last = 1'b1;
      end
      if (n == 2'd2) begin
         r1.last = 1'b1;
      end
      step.count = n;
      step.first = r0;
      step.second = r1;
   end

   // state registers advance only when a transfer is processed
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cur_ff <= '0;
         left_ff <= '0;
         next_hdr_ff <= '0;
         end_ff <= 1'b0;
         lat_from_ff <= 1'b0;
         lat_down_ff <= 1'b0;
      end else if (go) begin
         phase_ff <= phase_in;
         cur_ff <= cur_in;
         left_ff <= left_in;
         next_hdr_ff <= next_hdr_in;
         end_ff <= end_in;
         lat_from_ff <= lat_from_in;
         lat_down_ff <= lat_down_in;
      end
   end

endmodule

// ----- rtl/core/dmablt_rsp_fifo.sv -----
// result queue: takes up to two results per cycle, hands out one per transfer
// depends on dmablt_pkg
module dmablt_rsp_fifo (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  dmablt_pkg::step_type         step,
   input  logic                         pop,
   output dmablt_pkg::result_type       head,
   output dmablt_pkg::fifo_status_type  status
);

   localparam int PW = dmablt_pkg::FIFO_PTR_W;
   localparam int CW = dmablt_pkg::FIFO_CNT_W;

   dmablt_pkg::result_type mem_ff [dmablt_pkg::FIFO_DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]    n;
   logic [PW-1:0] wr_next;

   assign n = push ? step.count : 2'd0;
   assign wr_next = wr_ff + PW'(1);
   assign wr_in = wr_ff + PW'(n);
   assign rd_in = rd_ff + PW'(pop);
   assign count_in = count_ff + CW'(n) - CW'(pop);

   // entry storage
   always_ff @(posedge clock) begin
      if (n != 2'd0) begin
         mem_ff[wr_ff] <= step.first;
      end
      if (n == 2'd2) begin
         mem_ff[wr_next] <= step.second;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   assign head = mem_ff[rd_ff];
   assign status.valid = (count_ff != '0);
   assign status.room2 = (count_ff <= CW'(dmablt_pkg::FIFO_DEPTH - 2));
   assign status.count = count_ff;

endmodule

// ----- rtl/core/dma_block_and_list_transfer.sv -----
// One DMA channel controller for block and linked-list transfers.
// Configuration: csr_write with csr_index 0..5 writes base_address,
// word_count, step_down, from_ram, linked_list and channel_kind; other
// indexes are dropped. Write only while the channel is idle.
// Request channel (req_*): a transfer carries an operation (start, read data
// returned, write acknowledged) and the returned read word. Response channel
// (rsp_*): each transfer is one result (read request, memory write, GPU word,
// done, error); last marks the final result of a request.
// A request is taken into the request register and then processed into the result
// queue, whose head is offered as the response.
// Throughput: one request per cycle while the four-entry result queue has room
// for two results; results leave at one per cycle while rsp_stall is low, so
// requests that cause two results fill the queue and then make req_stall rise.
// Reset clears the configuration, the channel state (idle) and the queue.
// While rsp_stall is high the head result holds; the queue fills, then the
// request register holds and req_stall rises.
// depends on dmablt_pkg, dmablt_core, dmablt_rsp_fifo, assert_macros.svh
`include "assert_macros.svh"

module dma_block_and_list_transfer (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_read_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [20:0] rsp_address,
   output logic [31:0] rsp_data,
   output logic        rsp_last
);

   localparam logic [2:0] R_BASE = 3'd0;
   localparam logic [2:0] R_COUNT = 3'd1;
   localparam logic [2:0] R_STEP = 3'd2;
   localparam logic [2:0] R_FROM = 3'd3;
   localparam logic [2:0] R_LIST = 3'd4;
   localparam logic [2:0] R_KIND = 3'd5;

   dmablt_pkg::cfg_type         cfg_ff;
   dmablt_pkg::step_type        step;
   dmablt_pkg::result_type      head;
   dmablt_pkg::fifo_status_type fifo_status;

   logic        in_valid_ff;
   logic [1:0]  in_op_ff;
   logic [31:0] in_data_ff;
   logic        go;
   logic        pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            R_BASE: cfg_ff.base_address <= csr_data;
            R_COUNT: cfg_ff.word_count <= csr_data;
            R_STEP: cfg_ff.step_down <= csr_data[0];
            R_FROM: cfg_ff.from_ram <= csr_data[0];
            R_LIST: cfg_ff.linked_list <= csr_data[0];
            R_KIND: cfg_ff.channel_kind <= csr_data[1:0];
            default: begin
               // unused index
            end
         endcase
      end
   end

   // request register
   assign go = in_valid_ff && fifo_status.room2;
   assign req_stall = in_valid_ff && !go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_op_ff <= req_operation;
         in_data_ff <= req_read_data;
      end
   end

   dmablt_core u_core (
      .clock (clock),
      .reset (reset),
      .go    (go),
      .op    (in_op_ff),
      .rd    (in_data_ff),
      .cfg   (cfg_ff),
      .step  (step)
   );

   // result queue and response channel
   assign pop = fifo_status.valid && !rsp_stall;

   dmablt_rsp_fifo u_rsp_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (go),
      .step   (step),
      .pop    (pop),
      .head   (head),
      .status (fifo_status)
   );

   assign rsp_valid = fifo_status.valid;
   assign rsp_kind = head.kind;
   assign rsp_address = head.address;
   assign rsp_data = head.data;
   assign rsp_last = head.last;

   // checks
   `DMABLT_NEVER(a_fifo_bound, fifo_status.count > 3'(dmablt_pkg::FIFO_DEPTH), "queue overflow")
   `DMABLT_ASSERT(a_end_last, rsp_valid && rsp_kind > dmablt_pkg::K_GPU |-> rsp_last, "end not last")
   `DMABLT_ASSERT(a_req_hold, req_stall |=> $stable({in_valid_ff, in_op_ff, in_data_ff}), "hold lost")

endmodule

// ----- bench/dmablt_bench_pkg.sv -----
// scoreboard of the dma block and list transfer bench: channel predictor and result check
// depends on dmablt_pkg for the operation, result and channel codes and the result struct
`timescale 1ns / 100ps

package dmablt_bench_pkg;
   import dmablt_pkg::*;

   // operation code the block must drop
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // channel kinds with no transfer support
   localparam logic [1:0] CH_SPARE = 2'd2;
   localparam logic [1:0] CH_OTHER = 2'd3;

   // register indexes of the write port
   localparam logic [2:0] REG_BASE = 3'd0;
   localparam logic [2:0] REG_COUNT = 3'd1;
   localparam logic [2:0] REG_STEP_DOWN = 3'd2;
   localparam logic [2:0] REG_FROM_RAM = 3'd3;
   localparam logic [2:0] REG_LINKED = 3'd4;
   localparam logic [2:0] REG_CHANNEL = 3'd5;
   localparam logic [2:0] REG_UNUSED_LO = 3'd6;
   localparam logic [2:0] REG_UNUSED_HI = 3'd7;

   localparam logic [20:0] WORD_MASK = 21'h1FFFFC;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_BLOCK,
      PH_HEADER,
      PH_WORD
   } chan_phase_type;

   class dma_channel_scoreboard;
      // register copy
      logic [23:0] base_address;
      logic [23:0] word_count;
      logic        step_down;
      logic        from_ram;
      logic        linked_list;
      logic [1:0]  channel_kind;

      // channel state
      chan_phase_type phase;
      logic [31:0] cur_address;
      logic [23:0] words_left;
      logic [20:0] next_header;
      logic        end_marked;
      logic        held_from_ram;
      logic        held_step_down;

      result_type pending_results[$];
      result_type step_results[$];
      int failures;

      function new();
         base_address = '0;
         word_count = '0;
         step_down = 1'b0;
         from_ram = 1'b0;
         linked_list = 1'b0;
         channel_kind = '0;
         phase = PH_IDLE;
         cur_address = '0;
         words_left = '0;
         next_header = '0;
         end_marked = 1'b0;
         held_from_ram = 1'b0;
         held_step_down = 1'b0;
         failures = 0;
      endfunction

      function void set_register(logic [2:0] index, logic [23:0] value);
         case (index)
            REG_BASE: base_address = value;
            REG_COUNT: word_count = value;
            REG_STEP_DOWN: step_down = value[0];
            REG_FROM_RAM: from_ram = value[0];
            REG_LINKED: linked_list = value[0];
            REG_CHANNEL: channel_kind = value[1:0];
            default: ;
         endcase
      endfunction

      function void issue(logic [2:0] kind, logic [20:0] address, logic [31:0] data);
         result_type r;
         r.kind = kind;
         r.address = address;
         r.data = data;
         r.last = 1'b0;
         step_results.push_back(r);
      endfunction

      function logic [20:0] word_addr();
         return cur_address[20:0] & WORD_MASK;
      endfunction

      // ordering table entry links to the word below, the final one ends the table
      function void ot_write();
         logic [20:0] a;
         a = word_addr();
         issue(K_WRITE, a, (words_left == 24'd1) ? OT_END : {11'd0, a - 21'd4});
      endfunction

      // node finished: stop on the end bit or fetch the next header
      function void list_next();
         if (end_marked) begin
            phase = PH_IDLE;
            issue(K_DONE, '0, '0);
            return;
         end
         cur_address = {11'd0, next_header & WORD_MASK};
         phase = PH_HEADER;
         issue(K_READ, word_addr(), '0);
      endfunction

      function void advance(logic [1:0] op, logic [31:0] rd);
         // start only from idle; checks the setup and latches direction
         if (op == OP_START) begin
            if (phase != PH_IDLE)
               return;
            cur_address = {8'd0, base_address};
            held_from_ram = from_ram;
            held_step_down = step_down;
            if (linked_list) begin
               if (!from_ram || channel_kind != CH_GPU) begin
                  issue(K_ERROR, '0, '0);
                  return;
               end
               words_left = '0;
               end_marked = 1'b0;
               phase = PH_HEADER;
               issue(K_READ, word_addr(), '0);
               return;
            end
            if (from_ram ? (channel_kind != CH_GPU) : (channel_kind != CH_OT)) begin
               issue(K_ERROR, '0, '0);
               return;
            end
            words_left = word_count;
            if (words_left == '0) begin
               issue(K_DONE, '0, '0);
               return;
            end
            phase = PH_BLOCK;
            if (from_ram)
               issue(K_READ, word_addr(), '0);
            else
               ot_write();
            return;
         end

         // block mode: one word per matching response
         if (phase == PH_BLOCK) begin
            if (held_from_ram ? (op != OP_READ_DATA) : (op != OP_WRITE_ACK))
               return;
            if (held_from_ram)
               issue(K_GPU, word_addr(), rd);
            cur_address = held_step_down ? cur_address - 32'd4 : cur_address + 32'd4;
            words_left = words_left - 24'd1;
            if (words_left == '0) begin
               phase = PH_IDLE;
               issue(K_DONE, '0, '0);
               return;
            end
            if (held_from_ram)
               issue(K_READ, word_addr(), '0);
            else
               ot_write();
            return;
         end

         if (op != OP_READ_DATA)
            return;

         // linked list: header then its data words
         case (phase)
            PH_HEADER: begin
               words_left = {16'd0, rd[31:24]};
               end_marked = rd[23];
               next_header = rd[20:0] & WORD_MASK;
               if (words_left != '0) begin
                  cur_address = {11'd0, (cur_address[20:0] + 21'd4) & WORD_MASK};
                  phase = PH_WORD;
                  issue(K_READ, word_addr(), '0);
               end else
                  list_next();
            end
            PH_WORD: begin
               issue(K_GPU, word_addr(), rd);
               words_left = words_left - 24'd1;
               if (words_left != '0) begin
                  cur_address = {11'd0, (cur_address[20:0] + 21'd4) & WORD_MASK};
                  issue(K_READ, word_addr(), '0);
               end else
                  list_next();
            end
            default: ;
         endcase
      endfunction

      // accepted request: queue its results, last flag on the final one
      function int predict_transfer(logic [1:0] op, logic [31:0] rd);
         result_type r;
         step_results.delete();
         advance(op, rd);
         for (int i = 0; i < step_results.size(); i++) begin
            r = step_results[i];
            r.last = (i == step_results.size() - 1);
            pending_results.push_back(r);
         end
         return step_results.size();
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (pending_results.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result: kind %0d address %h data %h last %b",
                        got.kind, got.address, got.data, got.last);
            return;
         end
         want = pending_results.pop_front();
         if (got.kind !== want.kind || got.address !== want.address ||
             got.data !== want.data || got.last !== want.last) begin
            failures++;
            if (failures <= 10)
               $display("result mismatch: expected kind %0d address %h data %h last %b, %s",
                        want.kind, want.address, want.data, want.last,
                        $sformatf("got kind %0d address %h data %h last %b",
                                  got.kind, got.address, got.data, got.last));
         end
      endfunction
   endclass

endpackage

// ----- bench/dma_block_and_list_transfer_test.sv -----
// top of the dma block and list transfer bench: clock, reset, drivers and run control
// depends on dmablt_pkg, dmablt_bench_pkg and the dma_block_and_list_transfer rtl
`timescale 1ns / 100ps

module dma_block_and_list_transfer_test;
   import dmablt_pkg::*;
   import dmablt_bench_pkg::*;

   localparam int RANDOM_ITEMS = 650;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 6;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = '0;
   logic [31:0] req_read_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [20:0] rsp_address;
   logic [31:0] rsp_data;
   logic        rsp_last;

   dma_channel_scoreboard book;
   int cycles = 0;
   int useful_items = 0;
   bit send_calm = 1'b0;
   bit take_calm = 1'b0;
   bit big_list_done = 1'b0;

   dma_block_and_list_transfer uut (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_read_data(req_read_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_address(rsp_address),
      .rsp_data(rsp_data),
      .rsp_last(rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic int draw_gap(input bit calm);
      return calm ? 0 : int'($urandom_range(0, 11));
   endfunction

   // one request transfer, predicted at the edge that takes it
   task automatic send_transfer(input logic [1:0] op, input logic [31:0] rd);
      int gap;
      if ($urandom_range(0, 39) == 0)
         send_calm = !send_calm;
      gap = draw_gap(send_calm);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_operation = op;
      req_read_data = rd;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (book.predict_transfer(op, rd) > 0)
         useful_items++;
   endtask

   // drop valid and let every expected result and the pipeline drain
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (book.pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [23:0] value);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = index;
      csr_data = value;
      @(negedge clock);
      csr_write = 1'b0;
      book.set_register(index, value);
   endtask

   // full register setup, junk in the unused upper bits of the narrow ones
   task automatic configure_channel(input logic [23:0] base, input logic [23:0] count,
                                    input logic down, input logic from,
                                    input logic linked, input logic [1:0] kind);
      logic [31:0] fill;
      settle();
      fill = $urandom;
      write_register(REG_BASE, base);
      write_register(REG_COUNT, count);
      write_register(REG_STEP_DOWN, {fill[22:0], down});
      write_register(REG_FROM_RAM, {fill[23:1], from});
      write_register(REG_LINKED, {fill[31:9], linked});
      write_register(REG_CHANNEL, {fill[29:8], kind});
   endtask

   // list header: mostly short nodes, some empty, about a third end the list
   function automatic logic [31:0] make_header();
      logic [31:0] h;
      int n;
      h = $urandom;
      n = $urandom_range(0, 9);
      if (n < 2)
         h[31:24] = 8'd0;
      else begin
         n = $urandom_range(1, 4);
         h[31:24] = n[7:0];
      end
      h[23] = ($urandom_range(0, 2) == 0);
      return h;
   endfunction

   // the response the channel waits for, with some noise mixed in
   task automatic feed_response();
      logic [1:0] op;
      logic [31:0] rd;
      logic [31:0] pick;
      rd = $urandom;
      case (book.phase)
         PH_BLOCK: op = book.held_from_ram ? OP_READ_DATA : OP_WRITE_ACK;
         PH_HEADER: begin
            op = OP_READ_DATA;
            rd = make_header();
            // one full-size node part way through the run
            if (!big_list_done && useful_items > 300) begin
               rd[31:24] = 8'hFF;
               rd[23] = 1'b1;
               big_list_done = 1'b1;
            end
         end
         default: op = OP_READ_DATA;
      endcase
      if ($urandom_range(0, 11) == 0) begin
         pick = $urandom;
         op = pick[1:0];
      end
      send_transfer(op, rd);
   endtask

   // random setup, a start, then responses until the channel is idle again
   task automatic run_random_phase();
      logic [31:0] r;
      logic [23:0] base;
      logic [23:0] count;
      logic down;
      logic from;
      logic linked;
      logic [1:0] kind;
      logic plain_block;
      int n;
      r = $urandom;
      base = r[23:0];
      r = $urandom;
      down = r[0];
      from = r[1];
      linked = r[2];
      kind = r[4:3];
      count = r[31:8];
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            linked = 1'b0;
            from = 1'b1;
            kind = CH_GPU;
         end
         3, 4, 5: begin
            linked = 1'b0;
            from = 1'b0;
            kind = CH_OT;
         end
         6, 7, 8: begin
            linked = 1'b1;
            from = 1'b1;
            kind = CH_GPU;
         end
         default: ;
      endcase
      // block transfers that will run keep short word counts
      plain_block = !linked && (from ? (kind == CH_GPU) : (kind == CH_OT));
      if (plain_block) begin
         n = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 6);
         count = n[23:0];
      end
      configure_channel(base, count, down, from, linked, kind);
      if ($urandom_range(0, 7) == 0) begin
         r = $urandom;
         send_transfer(r[0] ? OP_READ_DATA : OP_WRITE_ACK, $urandom);
         send_transfer(OP_UNUSED, $urandom);
      end
      send_transfer(OP_START, $urandom);
      while (book.phase != PH_IDLE)
         feed_response();
   endtask

   // result side: random stall before each result, check on the taking edge
   initial begin : result_sink
      int gap;
      result_type got;
      wait (!reset);
      forever begin
         if ($urandom_range(0, 39) == 0)
            take_calm = !take_calm;
         gap = draw_gap(take_calm);
         @(negedge clock);
         if (gap > 0) begin
            rsp_stall = 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall = 1'b0;
         @(posedge clock);
         while (!rsp_valid)
            @(posedge clock);
         got.kind = rsp_kind;
         got.address = rsp_address;
         got.data = rsp_data;
         got.last = rsp_last;
         book.check_result(got);
      end
   end

   initial begin : stimulus
      book = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset setup is block to ram on the gpu channel: unsupported
      send_transfer(OP_START, 32'hFFFF_FFFF);
      // responses and the spare opcode while idle are dropped
      send_transfer(OP_READ_DATA, 32'h0000_0000);
      send_transfer(OP_WRITE_ACK, 32'h1234_5678);
      send_transfer(OP_UNUSED, 32'hFFFF_FFFF);

      // writes to the spare indexes change nothing
      settle();
      write_register(REG_UNUSED_LO, 24'hFFFFFF);
      write_register(REG_UNUSED_HI, 24'h000001);

      // ordering table from the top of memory, counting down
      configure_channel(24'hFFFFFF, 24'd3, 1'b1, 1'b0, 1'b0, CH_OT);
      send_transfer(OP_START, 32'h0);
      send_transfer(OP_START, 32'h0);
      send_transfer(OP_READ_DATA, 32'h0);
      send_transfer(OP_WRITE_ACK, 32'h0);
      send_transfer(OP_WRITE_ACK, 32'hFFFF_FFFF);
      send_transfer(OP_WRITE_ACK, 32'h0);

      // empty block
      configure_channel(24'h000040, 24'd0, 1'b0, 1'b0, 1'b0, CH_OT);
      send_transfer(OP_START, 32'h0);

      // gpu block read from address zero counting down wraps to the top
      configure_channel(24'h000000, 24'd2, 1'b1, 1'b1, 1'b0, CH_GPU);
      send_transfer(OP_START, 32'h0);
      send_transfer(OP_READ_DATA, 32'hFFFF_FFFF);
      send_transfer(OP_WRITE_ACK, 32'h0);
      send_transfer(OP_READ_DATA, 32'h0000_0000);

      // list: two-word node, empty node, then a one-word end node that wraps
      configure_channel(24'h000100, 24'hFFFFFF, 1'b0, 1'b1, 1'b1, CH_GPU);
      send_transfer(OP_START, 32'h0);
      send_transfer(OP_READ_DATA, 32'h0200_0200);
      send_transfer(OP_READ_DATA, 32'hA5A5_5A5A);
      send_transfer(OP_READ_DATA, 32'h5A5A_A5A5);
      send_transfer(OP_READ_DATA, 32'h001F_FFFF);
      send_transfer(OP_READ_DATA, 32'h0180_0000);
      send_transfer(OP_READ_DATA, 32'hDEAD_BEEF);

      // unsupported combinations
      configure_channel(24'h000000, 24'hFFFFFF, 1'b0, 1'b0, 1'b1, CH_GPU);
      send_transfer(OP_START, 32'h0);
      configure_channel(24'hFFFFFF, 24'h000000, 1'b1, 1'b1, 1'b1, CH_OT);
      send_transfer(OP_START, 32'h0);
      configure_channel(24'h123456, 24'hFFFFFF, 1'b0, 1'b1, 1'b0, CH_OT);
      send_transfer(OP_START, 32'h0);
      configure_channel(24'h654321, 24'hFFFFFF, 1'b1, 1'b0, 1'b0, CH_OTHER);
      send_transfer(OP_START, 32'h0);
      configure_channel(24'h000004, 24'd1, 1'b0, 1'b1, 1'b0, CH_SPARE);
      send_transfer(OP_START, 32'h0);

      // random phases
      while (useful_items < RANDOM_ITEMS)
         run_random_phase();

      // largest word count, left running at the end of the run
      configure_channel(24'($urandom), 24'hFFFFFF, 1'b1, 1'b1, 1'b0, CH_GPU);
      send_transfer(OP_START, 32'h0);
      repeat (20) feed_response();

      settle();
      if (book.failures == 0 && book.pending_results.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/dmablt_pkg.sv
rtl/core/dmablt_core.sv
rtl/core/dmablt_rsp_fifo.sv
rtl/core/dma_block_and_list_transfer.sv
bench/dmablt_bench_pkg.sv
bench/dma_block_and_list_transfer_test.sv
